@@ rtl/core/fcs_pkg.sv @@
// shared types, widths and constants of the flash request command splitter
// no dependencies; imported by fcs_ctrl, fcs_dp and the top level
`default_nettype none

package fcs_pkg;

	// field widths
	localparam int ADDR_W = 24;
	localparam int CNT_W  = 14;
	localparam int ID_W   = 24;
	localparam int CAP_W  = ADDR_W + 1;

	// flash geometry, all powers of two
	localparam int PAGE_BYTES        = 256;
	localparam int SECTOR_BYTES      = 4096;
	localparam int BLOCK_BYTES       = 65536;
	localparam int MAX_REQUEST_BYTES = 8192;
	localparam int PAGE_W            = $clog2(PAGE_BYTES);

	// chip id decoding
	localparam logic [ID_W-1:0]  ID_NONE_LOW  = 24'h000000;
	localparam logic [ID_W-1:0]  ID_NONE_HIGH = 24'hFFFFFF;
	localparam logic [7:0]       DENSITY_MIN  = 8'h10;
	localparam logic [7:0]       DENSITY_MAX  = 8'h1F;
	localparam logic [7:0]       DENSITY_CLAMP = 8'(ADDR_W);
	localparam logic [CAP_W-1:0] CAP_LIMIT    = CAP_W'(16 * 1024 * 1024);

	// low-bit masks for aligning addresses down, sector step and maximum length
	localparam logic [ADDR_W-1:0] SECTOR_LOW = ADDR_W'(SECTOR_BYTES - 1);
	localparam logic [ADDR_W-1:0] BLOCK_LOW  = ADDR_W'(BLOCK_BYTES - 1);
	localparam logic [ADDR_W-1:0] SECTOR_STEP = ADDR_W'(SECTOR_BYTES);
	localparam logic [CNT_W-1:0]  MAX_LEN    = CNT_W'(MAX_REQUEST_BYTES);

	// stream word widths
	localparam int S_DATA_W = 40;
	localparam int S_USER_W = 3;
	localparam int M_DATA_W = 48;
	localparam int M_USER_W = 3;

	// request modes
	typedef enum logic [2:0] {
		MODE_READ         = 3'd0,
		MODE_WRITE        = 3'd1,
		MODE_ERASE_SECTOR = 3'd2,
		MODE_ERASE_BLOCK  = 3'd3,
		MODE_ERASE_RANGE  = 3'd4,
		MODE_ERASE_CHIP   = 3'd5
	} mode_t;

	// flash command kinds
	typedef enum logic [2:0] {
		KIND_FAST_READ    = 3'd0,
		KIND_PAGE_PROGRAM = 3'd1,
		KIND_SECTOR_ERASE = 3'd2,
		KIND_BLOCK_ERASE  = 3'd3,
		KIND_CHIP_ERASE   = 3'd4
	} kind_t;

	// result error codes
	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_NO_CHIP = 2'd1,
		ERR_ZERO    = 2'd2,
		ERR_RANGE   = 2'd3
	} err_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic plan;
		logic emit;
	} fcs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic drop;
		logic final_item;
		logic out_free;
	} fcs_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/fcs_ctrl.sv @@
// controller state machine of the flash request command splitter
// depends on fcs_pkg; drives fcs_dp through fcs_cmd_t
`default_nettype none

module fcs_ctrl
	import fcs_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  fcs_stat_t  stat,
	output fcs_cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   ready_q;

	// commands decoded from state
	always_comb begin
		cmd.load = in_valid && ready_q;
		cmd.plan = (state_q == ST_EVAL) && !stat.drop;
		cmd.emit = (state_q == ST_RUN) && stat.out_free;
	end

	assign in_ready = ready_q;

	// state and ready register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && ready_q) begin
						state_q <= ST_EVAL;
						ready_q <= 1'b0;
					end
				end
				ST_EVAL: begin
					if (stat.drop) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end else begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.emit && stat.final_item) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	// an accepted request is always evaluated next
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_EVAL))
		else $error("accepted request not evaluated");

	// no new request while a request is being split
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !cmd.load)
		else $error("request accepted during split");

	// ready only while idle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == ST_IDLE))
		else $error("ready outside idle");

endmodule

`default_nettype wire

@@ rtl/core/fcs_dp.sv @@
// datapath of the flash request command splitter: chip capacity, checks,
// page and sector split, output register; depends on fcs_pkg
`default_nettype none

module fcs_dp
	import fcs_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire  [ID_W-1:0]   cfg_wdata,
	input  wire  [2:0]        in_mode,
	input  wire  [ADDR_W-1:0] in_address,
	input  wire  [CNT_W-1:0]  in_length,
	input  fcs_cmd_t          cmd,
	output fcs_stat_t         stat,
	output logic              out_valid,
	input  wire               out_ready,
	output kind_t             out_kind,
	output logic [ADDR_W-1:0] out_address,
	output logic [CNT_W-1:0]  out_count,
	output logic              out_wen,
	output err_t              out_err,
	output logic              out_last
);

	typedef enum logic [1:0] {
		JOB_ERROR,
		JOB_SINGLE,
		JOB_PAGES,
		JOB_SECTORS
	} job_t;

	// chip capacity
	logic             chip_ok_q;
	logic [CAP_W-1:0] cap_q;

	// request
	logic [2:0]        mode_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  len_q;

	// job being split
	job_t              job_q;
	kind_t             kind_q;
	err_t              err_q;
	logic [ADDR_W-1:0] cur_q;
	logic [CNT_W-1:0]  rem_q;
	logic [ADDR_W-1:0] end_q;

	// output word
	logic              valid_q;
	kind_t             o_kind_q;
	logic [ADDR_W-1:0] o_addr_q;
	logic [CNT_W-1:0]  o_cnt_q;
	logic              o_wen_q;
	err_t              o_err_q;
	logic              o_last_q;

	// capacity decode on a chip id write
	logic [7:0]       id_code;
	logic             id_ok;
	logic [CAP_W-1:0] id_cap;

	always_comb begin
		id_code = cfg_wdata[7:0];
		id_ok   = (cfg_wdata != ID_NONE_LOW) && (cfg_wdata != ID_NONE_HIGH)
			&& (id_code >= DENSITY_MIN) && (id_code <= DENSITY_MAX);
		if (id_code >= DENSITY_CLAMP) begin
			id_cap = CAP_LIMIT;
		end else begin
			id_cap = CAP_W'(1) << id_code[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_ok_q <= 1'b0;
			cap_q     <= '0;
		end else if (cfg_we) begin
			chip_ok_q <= id_ok;
			cap_q     <= id_cap;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			addr_q <= in_address;
			len_q  <= in_length;
		end
	end

	// request checks and job plan
	logic [CAP_W-1:0]  sum_end;
	logic [CAP_W-1:0]  end_byte;
	logic              range_bad;
	logic              unit_bad;
	job_t              plan_job;
	kind_t             plan_kind;
	err_t              plan_err;
	logic [ADDR_W-1:0] plan_cur;
	logic [CNT_W-1:0]  plan_rem;
	logic [ADDR_W-1:0] plan_end;

	always_comb begin
		sum_end   = {1'b0, addr_q} + CAP_W'(len_q);
		end_byte  = sum_end - CAP_W'(1);
		range_bad = (len_q > MAX_LEN) || (sum_end > cap_q);
		unit_bad  = {1'b0, addr_q} >= cap_q;
		plan_job  = JOB_ERROR;
		plan_kind = KIND_FAST_READ;
		plan_err  = ERR_NONE;
		plan_cur  = addr_q;
		plan_rem  = len_q;
		plan_end  = end_byte[ADDR_W-1:0] & ~SECTOR_LOW;
		if (!chip_ok_q) begin
			plan_err = ERR_NO_CHIP;
		end else begin
			case (mode_q)
				MODE_ERASE_CHIP: begin
					plan_job  = JOB_SINGLE;
					plan_kind = KIND_CHIP_ERASE;
					plan_cur  = '0;
					plan_rem  = '0;
				end
				MODE_ERASE_SECTOR: begin
					if (unit_bad) begin
						plan_err = ERR_RANGE;
					end else begin
						plan_job  = JOB_SINGLE;
						plan_kind = KIND_SECTOR_ERASE;
						plan_cur  = addr_q & ~SECTOR_LOW;
						plan_rem  = '0;
					end
				end
				MODE_ERASE_BLOCK: begin
					if (unit_bad) begin
						plan_err = ERR_RANGE;
					end else begin
						plan_job  = JOB_SINGLE;
						plan_kind = KIND_BLOCK_ERASE;
						plan_cur  = addr_q & ~BLOCK_LOW;
						plan_rem  = '0;
					end
				end
				default: begin
					if (len_q == '0) begin
						plan_err = ERR_ZERO;
					end else if (range_bad) begin
						plan_err = ERR_RANGE;
					end else if (mode_q == MODE_READ) begin
						plan_job  = JOB_SINGLE;
						plan_kind = KIND_FAST_READ;
					end else if (mode_q == MODE_WRITE) begin
						plan_job  = JOB_PAGES;
						plan_kind = KIND_PAGE_PROGRAM;
					end else begin
						plan_job  = JOB_SECTORS;
						plan_kind = KIND_SECTOR_ERASE;
						plan_cur  = addr_q & ~SECTOR_LOW;
					end
				end
			endcase
		end
	end

	// next result word and job advance
	logic [PAGE_W:0]   space;
	logic [CNT_W-1:0]  chunk;
	kind_t             nx_kind;
	logic [ADDR_W-1:0] nx_addr;
	logic [CNT_W-1:0]  nx_cnt;
	logic              nx_wen;
	err_t              nx_err;
	logic              nx_last;

	always_comb begin
		space = (PAGE_W+1)'(PAGE_BYTES) - {1'b0, cur_q[PAGE_W-1:0]};
		chunk = (rem_q < CNT_W'(space)) ? rem_q : CNT_W'(space);
		nx_kind = kind_q;
		nx_addr = cur_q;
		nx_cnt  = '0;
		nx_wen  = 1'b1;
		nx_err  = ERR_NONE;
		nx_last = 1'b1;
		case (job_q)
			JOB_ERROR: begin
				nx_kind = KIND_FAST_READ;
				nx_addr = '0;
				nx_wen  = 1'b0;
				nx_err  = err_q;
			end
			JOB_SINGLE: begin
				nx_cnt = rem_q;
				nx_wen = (kind_q != KIND_FAST_READ);
			end
			JOB_PAGES: begin
				nx_cnt  = chunk;
				nx_last = (rem_q <= CNT_W'(space));
			end
			JOB_SECTORS: begin
				nx_last = (cur_q == end_q);
			end
			default: begin
				nx_err = err_q;
			end
		endcase
	end

	// job registers
	always_ff @(posedge clk) begin
		if (cmd.plan) begin
			job_q  <= plan_job;
			kind_q <= plan_kind;
			err_q  <= plan_err;
			cur_q  <= plan_cur;
			rem_q  <= plan_rem;
			end_q  <= plan_end;
		end else if (cmd.emit) begin
			if (job_q == JOB_PAGES) begin
				cur_q <= cur_q + ADDR_W'(chunk);
				rem_q <= rem_q - chunk;
			end else if (job_q == JOB_SECTORS) begin
				cur_q <= cur_q + SECTOR_STEP;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			o_kind_q <= nx_kind;
			o_addr_q <= nx_addr;
			o_cnt_q  <= nx_cnt;
			o_wen_q  <= nx_wen;
			o_err_q  <= nx_err;
			o_last_q <= nx_last;
		end
	end

	// status back to the controller
	always_comb begin
		stat.drop       = (mode_q > MODE_ERASE_CHIP);
		stat.final_item = nx_last;
		stat.out_free   = !valid_q || out_ready;
	end

	assign out_valid   = valid_q;
	assign out_kind    = o_kind_q;
	assign out_address = o_addr_q;
	assign out_count   = o_cnt_q;
	assign out_wen     = o_wen_q;
	assign out_err     = o_err_q;
	assign out_last    = o_last_q;

	// a new word never overwrites one that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!valid_q || out_ready))
		else $error("output word overwritten");

	// a page program always moves at least one byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && job_q == JOB_PAGES) |-> (chunk != '0))
		else $error("empty page chunk");

	// sector walk never passes its last sector
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && job_q == JOB_SECTORS) |-> (cur_q <= end_q))
		else $error("sector walk overrun");

endmodule

`default_nettype wire

@@ rtl/core/flash_request_command_splitter_unit.sv @@
// top level of the flash request command splitter
// depends on fcs_pkg, fcs_ctrl and fcs_dp
//
// channel  dir  handshake                       payload
// s_axis   in   s_axis_tvalid / s_axis_tready   tuser mode, tdata address, length
// m_axis   out  m_axis_tvalid / m_axis_tready   tuser kind, tdata command fields, tlast
// cfg      in   cfg_we                          cfg_wdata chip id
//
// a request is captured, then checked and planned, then split into result words
// at one word per cycle while m_axis is not stalled; a write splits into up to
// 33 page programs in the split loop of the datapath.
// modes 6 and 7 are dropped at the check with no result.
// s_axis_tready is low from acceptance until the last word enters the output
// register; a stalled m_axis holds the loop. reset clears the chip id (no chip).
`default_nettype none

module flash_request_command_splitter_unit
	import fcs_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	// configuration
	input  wire                 cfg_we,
	input  wire  [ID_W-1:0]     cfg_wdata,     // chip_id
	// requests
	input  wire                 s_axis_tvalid,
	output logic                s_axis_tready,
	input  wire  [S_DATA_W-1:0] s_axis_tdata,  // address[23:0], length[37:24], zero pad
	input  wire  [S_USER_W-1:0] s_axis_tuser,  // mode[2:0]
	// commands
	output logic                m_axis_tvalid,
	input  wire                 m_axis_tready,
	output logic [M_DATA_W-1:0] m_axis_tdata,  // command_address[23:0], byte_count[37:24],
	                                           // needs_write_enable[38], error_code[40:39]
	output logic [M_USER_W-1:0] m_axis_tuser,  // command_kind[2:0]
	output logic                m_axis_tlast
);

	fcs_cmd_t          cmd;
	fcs_stat_t         stat;
	kind_t             out_kind;
	logic [ADDR_W-1:0] out_address;
	logic [CNT_W-1:0]  out_count;
	logic              out_wen;
	err_t              out_err;

	// controller
	fcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	fcs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_mode     (s_axis_tuser[2:0]),
		.in_address  (s_axis_tdata[ADDR_W-1:0]),
		.in_length   (s_axis_tdata[ADDR_W+CNT_W-1:ADDR_W]),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_kind    (out_kind),
		.out_address (out_address),
		.out_count   (out_count),
		.out_wen     (out_wen),
		.out_err     (out_err),
		.out_last    (m_axis_tlast)
	);

	// pack the result word
	assign m_axis_tdata = {
		(M_DATA_W - ADDR_W - CNT_W - 3)'(0),
		out_err,
		out_wen,
		out_count,
		out_address
	};
	assign m_axis_tuser = out_kind;

endmodule

`default_nettype wire
